// ===== rtl/core/binaural_delay_gain_panner_unit_macros.svh =====
// Assertion helpers for the panner checker.
`ifndef BINAURAL_DELAY_GAIN_PANNER_UNIT_MACROS_SVH
`define BINAURAL_DELAY_GAIN_PANNER_UNIT_MACROS_SVH

// same-cycle implication
`define BDGP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("panner check failed");

// next-cycle implication
`define BDGP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("panner check failed");

// fixed delay implication
`define BDGP_ASSERT_AFTER(label, ante, n, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("panner check failed");

`endif

// ===== rtl/core/bdgp_pkg.sv =====
`default_nettype none

package bdgp_pkg;

  localparam int DATA_W  = 16;
  localparam int DLY_W   = 14;
  localparam int GAIN_W  = 16;
  localparam int FRAC_W  = 8;
  localparam int WHOLE_W = DLY_W - FRAC_W;
  localparam int POS_W   = WHOLE_W + 1;        // whole + 1 can reach 2**WHOLE_W
  localparam int WGT_W   = FRAC_W + 1;         // 256 - frac needs one more bit
  localparam int TAP_W   = DATA_W + FRAC_W + 1;
  localparam int PROD_W  = TAP_W + GAIN_W;
  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd16384;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_DELAY_L = 2'd0;
  localparam logic [1:0] REG_DELAY_R = 2'd1;
  localparam logic [1:0] REG_GAIN_L  = 2'd2;
  localparam logic [1:0] REG_GAIN_R  = 2'd3;

  typedef struct packed {
    logic [DLY_W-1:0]  delay_l;
    logic [DLY_W-1:0]  delay_r;
    logic [GAIN_W-1:0] gain_l;
    logic [GAIN_W-1:0] gain_r;
  } bdgp_cfg_t;

  // ear select: 0 = left, 1 = right
  typedef struct packed {
    logic wr;         // push input word into delay line
    logic rd_en;      // read one tap
    logic rd_ear;
    logic rd_hi;      // floor(d)+1 instead of floor(d)
    logic mac_en;     // interpolation multiply
    logic mac_ear;
    logic mac_acc;    // accumulate (upper tap) instead of load
    logic gain_en;    // gain multiply on finished tap
    logic gain_ear;
    logic hold_left;  // round left product into holding register
    logic load_out;   // load result pair into output register
  } bdgp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/bdgp_regs.sv =====
`default_nettype none

module bdgp_regs
  import bdgp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output bdgp_cfg_t              cfg_o
);

  bdgp_cfg_t cfg_q, cfg_d;
  logic      wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_DELAY_L: cfg_d.delay_l = pwdata[DLY_W-1:0];
        REG_DELAY_R: cfg_d.delay_r = pwdata[DLY_W-1:0];
        REG_GAIN_L:  cfg_d.gain_l  = pwdata[GAIN_W-1:0];
        REG_GAIN_R:  cfg_d.gain_r  = pwdata[GAIN_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_l <= '0;
      cfg_q.delay_r <= '0;
      cfg_q.gain_l  <= GAIN_UNITY;
      cfg_q.gain_r  <= GAIN_UNITY;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_DELAY_L: prdata = APB_DW'(cfg_q.delay_l);
      REG_DELAY_R: prdata = APB_DW'(cfg_q.delay_r);
      REG_GAIN_L:  prdata = APB_DW'(cfg_q.gain_l);
      REG_GAIN_R:  prdata = APB_DW'(cfg_q.gain_r);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/core/bdgp_ctrl.sv =====
`default_nettype none

module bdgp_ctrl
  import bdgp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_tvalid_i,
  output logic      s_tready_o,
  input  wire logic out_free_i,
  output bdgp_cmd_t cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_L0   = 8'b0000_0010,
    ST_L1   = 8'b0000_0100,
    ST_R0   = 8'b0000_1000,
    ST_R1   = 8'b0001_0000,
    ST_RR   = 8'b0010_0000,
    ST_GR   = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } bdgp_state_e;

  bdgp_state_e st_q, st_d;

  assign s_tready_o = (st_q == ST_IDLE);

  always_comb begin
    st_d  = st_q;
    cmd_o = '0;
    unique case (st_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.wr = 1'b1;
          st_d     = ST_L0;
        end
      end
      ST_L0: begin
        cmd_o.rd_en = 1'b1;
        st_d        = ST_L1;
      end
      ST_L1: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_hi  = 1'b1;
        cmd_o.mac_en = 1'b1;
        st_d         = ST_R0;
      end
      ST_R0: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_ear  = 1'b1;
        cmd_o.mac_en  = 1'b1;
        cmd_o.mac_acc = 1'b1;
        st_d          = ST_R1;
      end
      ST_R1: begin
        // left tap is complete: gain it while right interpolation starts
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_ear  = 1'b1;
        cmd_o.rd_hi   = 1'b1;
        cmd_o.gain_en = 1'b1;
        cmd_o.mac_en  = 1'b1;
        cmd_o.mac_ear = 1'b1;
        st_d          = ST_RR;
      end
      ST_RR: begin
        cmd_o.mac_en    = 1'b1;
        cmd_o.mac_ear   = 1'b1;
        cmd_o.mac_acc   = 1'b1;
        cmd_o.hold_left = 1'b1;
        st_d            = ST_GR;
      end
      ST_GR: begin
        cmd_o.gain_en  = 1'b1;
        cmd_o.gain_ear = 1'b1;
        st_d           = ST_FIN;
      end
      ST_FIN: begin
        if (out_free_i) begin
          cmd_o.load_out = 1'b1;
          st_d           = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bdgp_dp.sv =====
`default_nettype none

module bdgp_dp
  import bdgp_pkg::*;
#(
  parameter int DELAY_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bdgp_cmd_t         cmd_i,
  input  wire bdgp_cfg_t         cfg_i,
  input  wire logic [DATA_W-1:0] sample_i,
  input  wire logic              m_tready_i,
  output logic                   m_tvalid_o,
  output logic [2*DATA_W-1:0]    m_tdata_o,
  output logic                   out_free_o
);

  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int CNT_W = $clog2(DELAY_DEPTH + 1);
  localparam int CW    = ((AW > POS_W) ? AW : POS_W) + 1;

  logic [DATA_W-1:0] mem [DELAY_DEPTH];

  // wp_q addresses line position 0; cnt_q counts words written, saturating
  logic [AW-1:0]    wp_q, wp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic [DATA_W-1:0] rdata_q;
  logic              rd_ok_q;
  logic [AW-1:0]     raddr;
  logic              rd_ok;
  logic [DLY_W-1:0]  rdly;
  logic [POS_W-1:0]  pos;
  logic [CW-1:0]     pos_x, wp_x, diff;

  logic signed [TAP_W-1:0]  acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W:0]   prod_full;
  logic signed [DATA_W-1:0] left_q;
  logic                     out_valid_q;
  logic [2*DATA_W-1:0]      out_q;

  logic [DLY_W-1:0]        mdly;
  logic [FRAC_W-1:0]       frac;
  logic [WGT_W-1:0]        wgt;
  logic signed [DATA_W-1:0] y;
  logic signed [TAP_W:0]   mprod;
  logic [GAIN_W-1:0]       gsel;

  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0]         s;
    logic signed [PROD_W:0]         t;
    logic signed [PROD_W-22:0]      r;
    s = {p[PROD_W-1], p} + (PROD_W+1)'(2097152);
    // negative: bias so the arithmetic shift truncates toward zero
    t = s[PROD_W] ? s + (PROD_W+1)'(4194303) : s;
    r = t[PROD_W:22];
    if (r > (PROD_W-21)'(32767)) begin
      round_sat = 16'sh7fff;
    end else if (r < -(PROD_W-21)'(32768)) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = r[DATA_W-1:0];
    end
  endfunction

  // write pointer and fill count
  always_comb begin
    wp_d  = wp_q;
    cnt_d = cnt_q;
    if (cmd_i.wr) begin
      wp_d = (wp_q == AW'(DELAY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
      if (cnt_q != CNT_W'(DELAY_DEPTH)) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      cnt_q <= cnt_d;
    end
  end

  // tap address: position p lives at wp - p (mod depth); unwritten reads as zero
  assign rdly  = cmd_i.rd_ear ? cfg_i.delay_r : cfg_i.delay_l;
  assign pos   = {1'b0, rdly[DLY_W-1:FRAC_W]} + POS_W'(cmd_i.rd_hi);
  assign pos_x = CW'(pos);
  assign wp_x  = CW'(wp_q);
  assign rd_ok = (pos_x < CW'(cnt_q));

  always_comb begin
    if (wp_x >= pos_x) begin
      diff = wp_x - pos_x;
    end else begin
      diff = wp_x + CW'(DELAY_DEPTH) - pos_x;
    end
    raddr = rd_ok ? diff[AW-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[wp_d] <= sample_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[raddr];
      rd_ok_q <= rd_ok;
    end
  end

  // interpolation: y0*(256-f) + y1*f
  assign mdly  = cmd_i.mac_ear ? cfg_i.delay_r : cfg_i.delay_l;
  assign frac  = mdly[FRAC_W-1:0];
  assign wgt   = cmd_i.mac_acc ? {1'b0, frac} : WGT_W'(1 << FRAC_W) - {1'b0, frac};
  assign y     = rd_ok_q ? $signed(rdata_q) : '0;
  assign mprod = (TAP_W+1)'(y) * (TAP_W+1)'($signed({1'b0, wgt}));

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mac_en) begin
      acc_d = cmd_i.mac_acc ? acc_q + mprod[TAP_W-1:0] : mprod[TAP_W-1:0];
    end
  end

  assign gsel      = cmd_i.gain_ear ? cfg_i.gain_r : cfg_i.gain_l;
  assign prod_full = (PROD_W+1)'(acc_q) * (PROD_W+1)'($signed({1'b0, gsel}));

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.gain_en) begin
      prod_q <= prod_full[PROD_W-1:0];
    end
    if (cmd_i.hold_left) begin
      left_q <= round_sat(prod_q);
    end
    if (cmd_i.load_out) begin
      out_q <= {round_sat(prod_q), left_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_free_o = !out_valid_q || m_tready_i;
  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/binaural_delay_gain_panner_unit.sv =====
// Binaural delay/gain panner: mono in, left/right pair out.
// Input stream (s_axis): one 16-bit signed sample per word. Each accepted word
// enters a delay line; each ear then reads a fractional tap (linear interpolation
// between floor(d) and floor(d)+1, Q8 delay), scales it by a Q2.14 gain, adds one
// half, truncates toward zero and saturates to 16 bits.
// Output stream (m_axis): one word per input word, left in [15:0], right in [31:16].
// Timing: m_axis_tvalid is registered; it rises once the sequence has run L0, L1,
// R0, R1, RR, GR and FIN after the accepting edge. No new word is taken until the
// last has been through that per-item sequence of four delay-line reads through
// the single memory read port and the shared interpolation and gain multipliers.
// s_axis_tready is high only while the block is idle. A finished result sits in
// the output register; the next word is taken while it waits, and the sequence
// holds in its last step until the receiver takes the waiting word.
// Reset clears the line (a fill count makes unwritten taps read as zero, no
// clearing pass), sets delays to 0 and gains to unity.
// APB: delay_left 0x0, delay_right 0x4, gain_left 0x8, gain_right 0xC; write only
// while idle.
`default_nettype none

module binaural_delay_gain_panner_unit
  import bdgp_pkg::*;
#(
  parameter int DELAY_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [15:0]       s_axis_tdata,   // [15:0] sample_in
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [31:0]            m_axis_tdata    // [15:0] left_out, [31:16] right_out
);

  bdgp_cfg_t cfg;
  bdgp_cmd_t cmd;
  logic      out_free;

  bdgp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bdgp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .out_free_i (out_free),
    .cmd_o      (cmd)
  );

  bdgp_dp #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_i      (cfg),
    .sample_i   (s_axis_tdata),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .out_free_o (out_free)
  );

endmodule

`default_nettype wire

// ===== rtl/core/bdgp_checker.sv =====
`default_nettype none
`include "binaural_delay_gain_panner_unit_macros.svh"

module bdgp_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  `BDGP_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `BDGP_ASSERT_AFTER(a_busy_six, s_axis_tvalid && s_axis_tready, 6, !s_axis_tready)
  `BDGP_ASSERT_NOW(a_out_idle, $rose(m_axis_tvalid), s_axis_tready)
  `BDGP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `BDGP_ASSERT_NEXT(a_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

endmodule

bind binaural_delay_gain_panner_unit bdgp_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
